@@ rtl/core/swtb_pkg.sv @@
// Shared types and constants for the symbol weight table builder.
// Depends on nothing; every other file refers to it by scoped names.
package swtb_pkg;

   localparam int AlphabetSizeDefault = 256;
   localparam int CountBitsDefault    = 32;
   localparam int OpcodeBits          = 2;
   localparam int ByteBits            = 8;
   localparam int WeightBits          = 8;
   localparam int LengthBits          = 9;
   localparam int TotalBits           = 32;
   localparam int DivSteps            = 8;
   localparam logic [WeightBits-1:0] WeightFull = 8'hff;

   typedef enum logic [1:0] {
      OP_COUNT = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_SPARE = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CNT_RD,
      ST_CNT_WR,
      ST_SCAN,
      ST_PICK,
      ST_DIV,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic cnt_rd;
      logic cnt_wr;
      logic clear;
      logic scan_start;
      logic scan_run;
      logic div_start;
      logic div_step;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic in_range;
      logic scan_done;
      logic found;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

@@ rtl/core/swtb_if.sv @@
// Valid/ready channel interfaces for request and response items.
// Depends on swtb_pkg for field widths.
interface swtb_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [swtb_pkg::OpcodeBits-1:0]      opcode;
   logic [swtb_pkg::ByteBits-1:0]        data_byte;

   modport source (output valid, output opcode, output data_byte, input ready);
   modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

interface swtb_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [swtb_pkg::ByteBits-1:0]        entry_symbol;
   logic [swtb_pkg::WeightBits-1:0]      entry_weight;
   logic                                 entry_valid;
   logic                                 last_entry;
   logic [swtb_pkg::LengthBits-1:0]      table_length;
   logic [swtb_pkg::TotalBits-1:0]       total_bytes;

   modport source (output valid, output entry_symbol, output entry_weight,
                   output entry_valid, output last_entry, output table_length,
                   output total_bytes, input ready);
   modport sink (input valid, input entry_symbol, input entry_weight,
                 input entry_valid, input last_entry, input table_length,
                 input total_bytes, output ready);
endinterface

@@ rtl/core/swtb_ctrl.sv @@
// Sequencing state machine: accepts items and steps the datapath.
// Depends on swtb_pkg.
module swtb_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic [swtb_pkg::OpcodeBits-1:0]  req_opcode,
   output logic                             req_ready,
   input  swtb_pkg::status_type             status,
   output swtb_pkg::cmd_type                cmd
);

   swtb_pkg::state_type  state_ff, state_in;
   swtb_pkg::opcode_type op;
   logic                 accept;

   assign op     = swtb_pkg::opcode_type'(req_opcode);
   assign accept = req_valid && req_ready;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swtb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         swtb_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               cmd.load = 1'b1;
               unique case (op)
                  swtb_pkg::OP_COUNT: begin
                     if (status.in_range) begin
                        state_in = swtb_pkg::ST_CNT_RD;
                     end
                  end
                  swtb_pkg::OP_READ: begin
                     cmd.scan_start = 1'b1;
                     state_in       = swtb_pkg::ST_SCAN;
                  end
                  swtb_pkg::OP_CLEAR: cmd.clear = 1'b1;
                  swtb_pkg::OP_SPARE: ;
               endcase
            end
         end
         swtb_pkg::ST_CNT_RD: begin
            cmd.cnt_rd = 1'b1;
            state_in   = swtb_pkg::ST_CNT_WR;
         end
         swtb_pkg::ST_CNT_WR: begin
            cmd.cnt_wr = 1'b1;
            state_in   = swtb_pkg::ST_IDLE;
         end
         swtb_pkg::ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (status.scan_done) begin
               state_in = swtb_pkg::ST_PICK;
            end
         end
         swtb_pkg::ST_PICK: begin
            if (status.found) begin
               cmd.div_start = 1'b1;
               state_in      = swtb_pkg::ST_DIV;
            end else begin
               state_in = swtb_pkg::ST_OUT;
            end
         end
         swtb_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = swtb_pkg::ST_OUT;
            end
         end
         swtb_pkg::ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = swtb_pkg::ST_IDLE;
            end
         end
         default: state_in = swtb_pkg::ST_IDLE;
      endcase
   end

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.cnt_rd, cmd.cnt_wr, cmd.clear, cmd.scan_start, cmd.scan_run,
                cmd.div_start, cmd.div_step, cmd.out_load}))
      else $error("more than one datapath command at once");

   a_count_pair: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_rd |=> cmd.cnt_wr)
      else $error("count read not followed by its write");

   a_read_scans: assert property (@(posedge clock) disable iff (reset)
      accept && op == swtb_pkg::OP_READ |=> state_ff == swtb_pkg::ST_SCAN)
      else $error("read item did not start a scan");

endmodule

@@ rtl/core/swtb_dp.sv @@
// Datapath: count memory with valid bits, ordering scan, weight divider,
// response register. Depends on swtb_pkg and swtb_rsp_if.
module swtb_dp #(
   parameter int ALPHABET_SIZE = swtb_pkg::AlphabetSizeDefault,
   parameter int COUNT_BITS    = swtb_pkg::CountBitsDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [swtb_pkg::ByteBits-1:0]  req_data_byte,
   input  swtb_pkg::cmd_type              cmd,
   output swtb_pkg::status_type           status,
   swtb_rsp_if.source                     rsp
);

   localparam int SymBits = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
   localparam int KeyBits = COUNT_BITS + SymBits;
   localparam logic [SymBits-1:0] LastSym = SymBits'(ALPHABET_SIZE - 1);
   localparam logic [SymBits:0]   NumSym  = (SymBits+1)'(ALPHABET_SIZE);
   localparam logic [COUNT_BITS-1:0] CountMax = '1;

   // count store; an entry whose valid bit is low reads as zero
   logic [COUNT_BITS-1:0]    mem [ALPHABET_SIZE];
   logic [ALPHABET_SIZE-1:0] vbits_ff;
   logic [COUNT_BITS-1:0]    mem_q_ff;
   logic                     vb_q_ff;
   logic [SymBits-1:0]       rd_addr;
   logic [COUNT_BITS-1:0]    cur_cnt;

   logic [SymBits-1:0]             sym_ff;
   logic [swtb_pkg::TotalBits-1:0] total_ff;
   logic                           ready_ff;
   logic [swtb_pkg::LengthBits-1:0] pos_ff;
   logic                           first_ff;
   logic [KeyBits-1:0]             prev_ff;

   // scan
   logic [SymBits:0]                scan_addr_ff;
   logic                            rd_live_ff;
   logic [SymBits-1:0]              rd_sym_ff;
   logic [COUNT_BITS-1:0]           max_ff;
   logic [swtb_pkg::LengthBits-1:0] len_ff;
   logic                            best_found_ff;
   logic [KeyBits-1:0]              best_ff;
   logic [KeyBits-1:0]              key;
   logic                            cand;

   // divider
   logic [COUNT_BITS:0]             rem_ff, rem_sh;
   logic [swtb_pkg::WeightBits-1:0] quo_ff;
   logic [2:0]                      div_cnt_ff;
   logic [COUNT_BITS-1:0]           best_cnt;
   logic [swtb_pkg::WeightBits-1:0] weight;

   logic out_free;

   assign rd_addr  = cmd.cnt_rd ? sym_ff : scan_addr_ff[SymBits-1:0];
   assign cur_cnt  = vb_q_ff ? mem_q_ff : '0;
   assign key      = {cur_cnt, rd_sym_ff};
   assign best_cnt = best_ff[KeyBits-1:SymBits];
   assign cand     = rd_live_ff && (cur_cnt != '0) && (first_ff || key > prev_ff)
                     && (!best_found_ff || key < best_ff);
   assign out_free = !rsp.valid || rsp.ready;

   assign status.in_range  = {1'b0, req_data_byte} < (swtb_pkg::ByteBits+1)'(ALPHABET_SIZE);
   assign status.scan_done = rd_live_ff && (rd_sym_ff == LastSym);
   assign status.found     = best_found_ff;
   assign status.div_done  = div_cnt_ff == 3'(swtb_pkg::DivSteps - 1);
   assign status.out_free  = out_free;

   // memory read and write
   always_ff @(posedge clock) begin
      mem_q_ff <= mem[rd_addr];
      vb_q_ff  <= vbits_ff[rd_addr];
      if (cmd.cnt_wr) begin
         mem[sym_ff] <= (cur_cnt == CountMax) ? cur_cnt : cur_cnt + 1'b1;
      end
   end

   // histogram control state
   always_ff @(posedge clock) begin
      if (reset) begin
         vbits_ff <= '0;
         total_ff <= '0;
         ready_ff <= 1'b0;
         pos_ff   <= '0;
         first_ff <= 1'b1;
      end else begin
         if (cmd.clear) begin
            vbits_ff <= '0;
            total_ff <= '0;
            ready_ff <= 1'b0;
            pos_ff   <= '0;
         end
         if (cmd.cnt_wr) begin
            vbits_ff[sym_ff] <= 1'b1;
            if (total_ff != '1) begin
               total_ff <= total_ff + 1'b1;
            end
            ready_ff <= 1'b0;
         end
         if (cmd.scan_start && !ready_ff) begin
            ready_ff <= 1'b1;
            pos_ff   <= '0;
            first_ff <= 1'b1;
         end
         if (cmd.out_load && best_found_ff) begin
            pos_ff   <= pos_ff + 1'b1;
            first_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sym_ff <= req_data_byte[SymBits-1:0];
      end
      if (cmd.out_load && best_found_ff) begin
         prev_ff <= best_ff;
      end
   end

   // scan: largest count, length, and smallest key above the last one sent
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_addr_ff  <= '0;
         rd_live_ff    <= 1'b0;
         best_found_ff <= 1'b0;
         max_ff        <= '0;
         len_ff        <= '0;
      end else if (cmd.clear) begin
         max_ff <= '0;
         len_ff <= '0;
      end else if (cmd.scan_start) begin
         scan_addr_ff  <= '0;
         rd_live_ff    <= 1'b0;
         best_found_ff <= 1'b0;
         max_ff        <= '0;
         len_ff        <= '0;
      end else if (cmd.scan_run) begin
         rd_live_ff <= scan_addr_ff < NumSym;
         rd_sym_ff  <= scan_addr_ff[SymBits-1:0];
         if (scan_addr_ff < NumSym) begin
            scan_addr_ff <= scan_addr_ff + 1'b1;
         end
         if (rd_live_ff && cur_cnt != '0) begin
            len_ff <= len_ff + 1'b1;
            if (cur_cnt > max_ff) begin
               max_ff <= cur_cnt;
            end
         end
         if (cand) begin
            best_found_ff <= 1'b1;
            best_ff       <= key;
         end
      end
   end

   // restoring division, one quotient bit a cycle: floor(256*c/m)
   assign rem_sh = {rem_ff[COUNT_BITS-1:0], 1'b0};
   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_start) begin
         rem_ff     <= {1'b0, best_cnt};
         quo_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + 1'b1;
         if (rem_sh >= {1'b0, max_ff}) begin
            rem_ff <= rem_sh - {1'b0, max_ff};
            quo_ff <= {quo_ff[swtb_pkg::WeightBits-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[swtb_pkg::WeightBits-2:0], 1'b0};
         end
      end
   end

   // 255c = q*m + (r - c): step down once when r < c
   always_comb begin
      if (best_cnt >= max_ff) begin
         weight = swtb_pkg::WeightFull;
      end else if (rem_ff < {1'b0, best_cnt}) begin
         weight = quo_ff - 1'b1;
      end else begin
         weight = quo_ff;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp.valid <= 1'b0;
      end else if (cmd.out_load) begin
         rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
         rsp.valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp.table_length <= len_ff;
         rsp.total_bytes  <= total_ff;
         rsp.entry_valid  <= best_found_ff;
         if (best_found_ff) begin
            rsp.entry_symbol <= swtb_pkg::ByteBits'(best_ff[SymBits-1:0]);
            rsp.entry_weight <= weight;
            rsp.last_entry   <= (pos_ff + 1'b1) == len_ff;
         end else begin
            rsp.entry_symbol <= '0;
            rsp.entry_weight <= '0;
            rsp.last_entry   <= 1'b0;
         end
      end
   end

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= swtb_pkg::LengthBits'(ALPHABET_SIZE))
      else $error("table length beyond symbol count");

   a_empty_item: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.out_load) && !rsp.entry_valid |->
         rsp.entry_symbol == '0 && rsp.entry_weight == '0 && !rsp.last_entry)
      else $error("empty item carries nonzero fields");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=>
         rsp.valid && $stable(rsp.entry_symbol) && $stable(rsp.entry_weight)
         && $stable(rsp.entry_valid) && $stable(rsp.last_entry)
         && $stable(rsp.table_length) && $stable(rsp.total_bytes))
      else $error("response item changed while stalled");

endmodule

@@ rtl/core/symbol_weight_table_builder.sv @@
// Byte histogram with an ordered, normalized weight table. A count item does a
// read-modify-write of the count memory; a clear item is taken in the idle
// state. Each read item sweeps the whole count memory once, one symbol a cycle,
// to find the next symbol in ascending (count, symbol) order along with the
// largest count and the table length, then, if a symbol was found, runs the
// divider for the weight, and then waits for the response slot. Counts reset
// to zero through one valid bit per symbol, so no clearing pass is needed.
// Depends on swtb_pkg, swtb_if, swtb_ctrl and swtb_dp.
module symbol_weight_table_builder #(
   parameter int ALPHABET_SIZE = swtb_pkg::AlphabetSizeDefault,
   parameter int COUNT_BITS    = swtb_pkg::CountBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   swtb_req_if.sink    req_chan,
   swtb_rsp_if.source  rsp_chan
);

   swtb_pkg::cmd_type    cmd;
   swtb_pkg::status_type status;
   logic                 req_ready;

   assign req_chan.ready = req_ready;

   swtb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.opcode),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   swtb_dp #(
      .ALPHABET_SIZE (ALPHABET_SIZE),
      .COUNT_BITS    (COUNT_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_data_byte (req_chan.data_byte),
      .cmd           (cmd),
      .status        (status),
      .rsp           (rsp_chan)
   );

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for symbol_weight_table_builder: random and directed
// count/read/clear traffic against a built-in histogram and table predictor.
// Depends on swtb_pkg, swtb_if and the RTL of the block.
`timescale 1ns / 1ps

module testbench;

   localparam int NumSym = swtb_pkg::AlphabetSizeDefault;
   localparam int SettleCycles = 2 * NumSym + 64;

   typedef struct {
      swtb_pkg::opcode_type op;
      logic [7:0] data;
      bit         drain;     // hold this item until all results are in
   } stim_item_type;

   typedef struct {
      logic [7:0]  symbol;
      logic [7:0]  weight;
      logic        present;
      logic        last;
      logic [8:0]  length;
      logic [31:0] total;
   } table_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   swtb_req_if req_bus ();
   swtb_rsp_if rsp_bus ();

   symbol_weight_table_builder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // predictor state
   logic [31:0] hist [NumSym];
   logic [31:0] byte_sum;
   logic [7:0]  order [NumSym];
   int          order_len;
   int          next_pos;
   logic [31:0] peak_count;
   bit          order_valid;

   stim_item_type   pending [$];
   table_entry_type expected_entries [$];

   int  error_count = 0;
   int  entries_checked = 0;
   int  items_sent = 0;
   int  reads_sent = 0;
   bit  req_taken = 0;
   bit  long_hold_done = 0;
   int  hold_left = 0;
   int  burst_left = 0;
   int  gap_left = 0;
   int  ready_mode = 0;
   int  mode_left = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #(100ms);
      $display("FAIL");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("mismatch on entry %0d: %s got %0h expected %0h",
               entries_checked, what, got, want);
   endtask

   // clear the histogram and table
   task automatic clear_histogram();
      for (int s = 0; s < NumSym; s++) hist[s] = '0;
      byte_sum = '0;
      order_len = 0;
      next_pos = 0;
      peak_count = '0;
      order_valid = 0;
   endtask

   // order nonzero symbols by ascending count, ties by ascending symbol
   task automatic sort_symbols();
      int j;
      order_len = 0;
      peak_count = '0;
      for (int s = 0; s < NumSym; s++) begin
         if (hist[s] != 0) begin
            if (hist[s] > peak_count) peak_count = hist[s];
            j = order_len;
            while (j > 0 && hist[order[j-1]] > hist[s]) begin
               order[j] = order[j-1];
               j--;
            end
            order[j] = s[7:0];
            order_len++;
         end
      end
      next_pos = 0;
      order_valid = 1;
   endtask

   task automatic predict_item(input swtb_pkg::opcode_type op, input logic [7:0] data);
      table_entry_type e;
      logic [63:0] scaled;
      case (op)
         swtb_pkg::OP_COUNT: begin
            if (hist[data] != 32'hffff_ffff) hist[data]++;
            if (byte_sum != 32'hffff_ffff) byte_sum++;
            order_valid = 0;
         end
         swtb_pkg::OP_CLEAR: clear_histogram();
         swtb_pkg::OP_READ: begin
            if (!order_valid) sort_symbols();
            e = '{8'd0, 8'd0, 1'b0, 1'b0, order_len[8:0], byte_sum};
            if (next_pos < order_len) begin
               scaled = 64'd255 * hist[order[next_pos]];
               e.symbol = order[next_pos];
               e.weight = 8'(scaled / peak_count);
               e.present = 1'b1;
               e.last = (next_pos + 1 == order_len);
               next_pos++;
            end
            expected_entries.push_back(e);
         end
         default: ;
      endcase
   endtask

   // sample both channels at the rising edge
   always @(posedge clock) begin
      table_entry_type e;
      if (!reset && req_bus.valid && req_bus.ready) begin
         req_taken = 1;
         predict_item(swtb_pkg::opcode_type'(req_bus.opcode), req_bus.data_byte);
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_entries.size() == 0) begin
            report_mismatch("unexpected entry", 32'(rsp_bus.entry_symbol), 32'd0);
         end else begin
            e = expected_entries.pop_front();
            if (rsp_bus.entry_symbol !== e.symbol)
               report_mismatch("entry_symbol", 32'(rsp_bus.entry_symbol), 32'(e.symbol));
            if (rsp_bus.entry_weight !== e.weight)
               report_mismatch("entry_weight", 32'(rsp_bus.entry_weight), 32'(e.weight));
            if (rsp_bus.entry_valid !== e.present)
               report_mismatch("entry_valid", 32'(rsp_bus.entry_valid), 32'(e.present));
            if (rsp_bus.last_entry !== e.last)
               report_mismatch("last_entry", 32'(rsp_bus.last_entry), 32'(e.last));
            if (rsp_bus.table_length !== e.length)
               report_mismatch("table_length", 32'(rsp_bus.table_length), 32'(e.length));
            if (rsp_bus.total_bytes !== e.total)
               report_mismatch("total_bytes", rsp_bus.total_bytes, e.total);
         end
         entries_checked++;
      end
   end

   // request driver: bursts with gaps, optional drain before an item
   always @(negedge clock) begin
      stim_item_type it;
      logic       nxt_valid;
      logic [1:0] nxt_op;
      logic [7:0] nxt_data;
      nxt_valid = req_bus.valid;
      nxt_op = req_bus.opcode;
      nxt_data = req_bus.data_byte;
      if (reset) begin
         nxt_valid = 1'b0;
         nxt_op = swtb_pkg::OP_COUNT;
         nxt_data = 8'd0;
      end else if (!req_bus.valid || req_taken) begin
         req_taken = 0;
         nxt_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending.size() != 0 &&
                      !(pending[0].drain && expected_entries.size() != 0)) begin
            it = pending.pop_front();
            nxt_valid = 1'b1;
            nxt_op = it.op;
            nxt_data = it.data;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
      req_bus.valid <= nxt_valid;
      req_bus.opcode <= nxt_op;
      req_bus.data_byte <= nxt_data;
   end

   // response ready: shifting stall pattern plus one long hold
   always @(negedge clock) begin
      logic nxt_ready;
      if (mode_left == 0) begin
         ready_mode = $urandom_range(0, 3);
         mode_left = $urandom_range(16, 128);
      end else begin
         mode_left--;
      end
      if (!long_hold_done && entries_checked >= 30) begin
         long_hold_done = 1;
         hold_left = 3000;
      end
      if (hold_left > 0) begin
         hold_left--;
         nxt_ready = 1'b0;
      end else begin
         case (ready_mode)
            0: nxt_ready = 1'b1;
            1: nxt_ready = 1'($urandom_range(0, 1));
            2: nxt_ready = (mode_left % 3) != 0;
            default: nxt_ready = ($urandom_range(0, 7) == 0);
         endcase
      end
      rsp_bus.ready <= nxt_ready;
   end

   task automatic add_item(input swtb_pkg::opcode_type op, input logic [7:0] data,
                           input bit drain = 0);
      pending.push_back('{op, data, drain});
      if (op != swtb_pkg::OP_SPARE) items_sent++;
      if (op == swtb_pkg::OP_READ) reads_sent++;
   endtask

   initial begin
      int n_counts, n_reads, base, span;
      clear_histogram();

      // directed: empty read, extremes, ties, exhaustion, spare, rebuild, clear
      add_item(swtb_pkg::OP_READ, 8'h00);
      add_item(swtb_pkg::OP_COUNT, 8'hff);
      add_item(swtb_pkg::OP_COUNT, 8'h00);
      add_item(swtb_pkg::OP_COUNT, 8'h00);
      add_item(swtb_pkg::OP_COUNT, 8'h55);
      add_item(swtb_pkg::OP_COUNT, 8'haa);
      add_item(swtb_pkg::OP_COUNT, 8'h00);
      add_item(swtb_pkg::OP_SPARE, 8'h12);
      for (int i = 0; i < 6; i++) add_item(swtb_pkg::OP_READ, 8'hff);
      add_item(swtb_pkg::OP_COUNT, 8'haa);
      add_item(swtb_pkg::OP_READ, 8'h00);
      add_item(swtb_pkg::OP_READ, 8'h00);
      add_item(swtb_pkg::OP_CLEAR, 8'h00);
      add_item(swtb_pkg::OP_READ, 8'h00);
      add_item(swtb_pkg::OP_COUNT, 8'h80, 1);
      add_item(swtb_pkg::OP_READ, 8'h00);
      add_item(swtb_pkg::OP_READ, 8'h00);

      // random: mostly count bursts followed by read runs, some noise
      while (items_sent < 1400) begin
         if ($urandom_range(0, 4) != 0) begin
            if ($urandom_range(0, 3) == 0) add_item(swtb_pkg::OP_CLEAR, 8'($urandom));
            n_counts = $urandom_range(1, 24);
            span = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 8);
            base = $urandom_range(0, 255 - span);
            for (int i = 0; i < n_counts; i++)
               add_item(swtb_pkg::OP_COUNT, 8'(base + $urandom_range(0, span)));
            n_reads = $urandom_range(1, 10);
            for (int i = 0; i < n_reads; i++)
               add_item(swtb_pkg::OP_READ, 8'($urandom), ($urandom_range(0, 60) == 0));
         end else begin
            for (int i = 0; i < 6; i++)
               add_item(swtb_pkg::opcode_type'($urandom_range(0, 3)), 8'($urandom));
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      wait (pending.size() == 0);
      @(posedge clock);
      while (req_bus.valid) @(posedge clock);
      wait (expected_entries.size() == 0);
      repeat (SettleCycles) @(posedge clock);

      $display("ran %0d items with %0d reads; %0d table entries checked",
               items_sent, reads_sent, entries_checked);
      $display("covered empty and exhausted tables, ties, rebuilds, clears and stalls");
      if (error_count == 0 && expected_entries.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/swtb_pkg.sv
rtl/core/swtb_if.sv
rtl/core/swtb_ctrl.sv
rtl/core/swtb_dp.sv
rtl/core/symbol_weight_table_builder.sv
bench/testbench.sv
